// ----- rtl/oarr_pkg.sv -----
// Package for the ordered array block: transaction payloads, codes and control structs.
`timescale 1ns / 1ps
`default_nettype none

package oarr_pkg;

  // Command codes
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_ERASE  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [6:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [6:0]         fill_count;
    logic [1:0]         status;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       ptr_ld_cnt;
    logic       ptr_ld_pos;
    logic       ptr_step;
    logic       rd_pos;
    logic       rd_shift;
    logic       wr_append;
    logic       wr_insert;
    logic       wr_shift;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       res_ld;
    logic       res_rdata;
    logic [1:0] res_status;
    logic       out_ld;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       cnt_zero;
    logic       cnt_full;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       shift_done;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/oarr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module oarr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/oarr_dp.sv -----
// Datapath of the ordered array: entry RAM, count, shift pointer, result and output registers.
`timescale 1ns / 1ps
`default_nettype none

module oarr_dp
  import oarr_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire in_t  in_data,
  input  wire logic out_ready,
  output logic      out_valid,
  output out_t      out_data,
  input  wire ctl_t ctl,
  output sts_t      sts
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  logic [2:0]         cmd_q;
  logic [6:0]         pos_q;
  logic signed [31:0] val_q;
  logic [CW-1:0]      cnt;
  logic [AW-1:0]      ptr;
  logic [31:0]        res_data;
  logic [1:0]         res_status;

  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] cnt_w;
  logic [CMPW-1:0] ptr_w;
  logic [AW-1:0]   shift_addr;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  assign pos_w = CMPW'(pos_q);
  assign cnt_w = CMPW'(cnt);
  assign ptr_w = CMPW'(ptr);

  // Insert walks down from the top, erase walks up from the position
  assign shift_addr = (cmd_q == CMD_INSERT) ? AW'(ptr - AW'(1)) : AW'(ptr + AW'(1));

  always_comb begin
    sts.cmd        = cmd_q;
    sts.cnt_zero   = (cnt_w == '0);
    sts.cnt_full   = (cnt_w >= CMPW'(DEPTH));
    sts.pos_gt_cnt = (pos_w > cnt_w);
    sts.pos_ge_cnt = (pos_w >= cnt_w);
    sts.shift_done = (cmd_q == CMD_INSERT) ? (ptr_w == pos_w)
                                           : (CMPW'(ptr_w + CMPW'(1)) == cnt_w);
    sts.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    ram_we    = ctl.wr_append || ctl.wr_insert || ctl.wr_shift;
    ram_waddr = ptr;
    ram_wdata = ram_rdata;
    if (ctl.wr_append) begin
      ram_waddr = cnt_w[AW-1:0];
      ram_wdata = val_q;
    end else if (ctl.wr_insert) begin
      ram_waddr = pos_w[AW-1:0];
      ram_wdata = val_q;
    end
    ram_re    = ctl.rd_pos || ctl.rd_shift;
    ram_raddr = ctl.rd_pos ? pos_w[AW-1:0] : shift_addr;
  end

  oarr_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      pos_q <= in_data.position;
      val_q <= in_data.value;
    end
    if (ctl.ptr_ld_cnt) begin
      ptr <= cnt_w[AW-1:0];
    end else if (ctl.ptr_ld_pos) begin
      ptr <= pos_w[AW-1:0];
    end else if (ctl.ptr_step) begin
      ptr <= shift_addr;
    end
    if (ctl.res_ld) begin
      res_data   <= ctl.res_rdata ? ram_rdata : 32'd0;
      res_status <= ctl.res_status;
    end
    if (ctl.out_ld) begin
      out_data.read_data  <= $signed(res_data);
      out_data.fill_count <= cnt_w[6:0];
      out_data.status     <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q     <= CMD_APPEND;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load_in) begin
        cmd_q <= in_data.cmd;
      end
      if (ctl.cnt_clr) begin
        cnt <= '0;
      end else if (ctl.cnt_inc) begin
        cnt <= CW'(cnt + CW'(1));
      end else if (ctl.cnt_dec) begin
        cnt <= CW'(cnt - CW'(1));
      end
      if (ctl.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/oarr_ctrl.sv -----
// Controller state machine of the ordered array: decode, shift sequencing, result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module oarr_ctrl
  import oarr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_SH_RD   = 3'd2;
  localparam logic [2:0] S_SH_WR   = 3'd3;
  localparam logic [2:0] S_RD_WAIT = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.res_ld     = 1'b1;
        ctl.res_status = ST_OK;
        state_next     = S_DONE;
        unique case (sts.cmd)
          CMD_APPEND: begin
            if (sts.cnt_full) begin
              ctl.res_status = ST_FULL;
            end else begin
              ctl.wr_append = 1'b1;
              ctl.cnt_inc   = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (sts.cnt_zero) begin
              ctl.res_status = ST_EMPTY;
            end else begin
              ctl.cnt_dec = 1'b1;
            end
          end
          CMD_INSERT: begin
            if (sts.pos_gt_cnt) begin
              ctl.res_status = ST_RANGE;
            end else if (sts.cnt_full) begin
              ctl.res_status = ST_FULL;
            end else begin
              ctl.res_ld     = 1'b0;
              ctl.ptr_ld_cnt = 1'b1;
              state_next     = S_SH_RD;
            end
          end
          CMD_ERASE: begin
            if (sts.cnt_zero) begin
              ctl.res_status = ST_EMPTY;
            end else if (sts.pos_ge_cnt) begin
              ctl.res_status = ST_RANGE;
            end else begin
              ctl.res_ld     = 1'b0;
              ctl.ptr_ld_pos = 1'b1;
              state_next     = S_SH_RD;
            end
          end
          CMD_READ: begin
            if (sts.cnt_zero) begin
              ctl.res_status = ST_EMPTY;
            end else if (sts.pos_ge_cnt) begin
              ctl.res_status = ST_RANGE;
            end else begin
              ctl.res_ld = 1'b0;
              ctl.rd_pos = 1'b1;
              state_next = S_RD_WAIT;
            end
          end
          CMD_CLEAR: begin
            ctl.cnt_clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SH_RD: begin
        if (sts.shift_done) begin
          // Gap is open (insert) or closed (erase): finish the command
          ctl.res_ld     = 1'b1;
          ctl.res_status = ST_OK;
          if (sts.cmd == CMD_INSERT) begin
            ctl.wr_insert = 1'b1;
            ctl.cnt_inc   = 1'b1;
          end else begin
            ctl.cnt_dec = 1'b1;
          end
          state_next = S_DONE;
        end else begin
          ctl.rd_shift = 1'b1;
          state_next   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.ptr_step = 1'b1;
        state_next   = S_SH_RD;
      end
      S_RD_WAIT: begin
        ctl.res_ld     = 1'b1;
        ctl.res_rdata  = 1'b1;
        ctl.res_status = ST_OK;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ordered_array_insert_erase.sv -----
// Top level of the ordered array: controller, datapath and interface checks.
//
// Bounded ordered array of signed 32-bit words held in a single-port-write RAM.
// Input channel in_valid/in_ready/in_data carries one command per transaction
// (append, remove last, insert at, erase at, read at, clear). Output channel
// out_valid/out_ready/out_data returns exactly one result per command: read
// data (zero unless a read succeeds), fill count after the command, status.
// Each entry moved by an insert or erase takes a RAM read in S_SH_RD and a
// RAM write in S_SH_WR, since the RAM has one read and one write port and
// registered read data; that loop sets the throughput of insert and erase.
// One command is in progress at a time: a new command is taken only after the
// previous result is loaded into the output register, and may be taken while
// that result still sits there. When the receiver stalls, the finished
// result waits inside the block and no further command is taken until the
// output register frees up. Reset clears the count, the controller and the
// output valid; RAM contents are not cleared, and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_insert_erase
  import oarr_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  ctl_t ctl;
  sts_t sts;

  // Sequence each transaction through decode, shift and result hand-off
  oarr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  // Hold entries, count and the output register
  oarr_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .ctl      (ctl),
    .sts      (sts)
  );

  // Never grow past the array depth
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    !(sts.cnt_full && ctl.cnt_inc))
    else $error("count incremented while full");

  // Never shrink below empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(sts.cnt_zero && ctl.cnt_dec))
    else $error("count decremented while empty");

  // Never overwrite a result the receiver has not taken
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_ld |-> sts.out_free)
    else $error("output register loaded while a result is pending");

  // One transaction at a time: stop taking commands right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted while another is in progress");

endmodule

`default_nettype wire

// ----- tb/ordered_array_insert_erase_tb.sv -----
// Self-checking testbench for the ordered array insert/erase block.
`timescale 1ns / 1ps

module ordered_array_insert_erase_tb;
  import oarr_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 500000;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ports of the block; every input starts at a known value
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  ordered_array_insert_erase #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Commands waiting to be driven, and results owed by the block in order
  in_t  cmd_q[$];
  out_t due_results[$];

  // Shadow copy of the array contents, updated as each command transaction is accepted
  logic signed [31:0] shadow_words [DEPTH];
  int                 shadow_count = 0;

  // Fill level as the generator expects it, so it can aim positions at live entries
  int gen_level = 0;

  int fail_count  = 0;
  int cycle_count = 0;

  // Idle state of each side: wait length before the next transaction and calm stretch
  int in_gap    = 0;
  int in_calm   = 0;
  int out_stall = 0;
  int out_calm  = 0;

  // Apply one command to the shadow array and return the result it must produce.
  function automatic out_t apply_array_cmd(in_t item);
    out_t res;
    int   pos;
    res = '0;
    res.status = ST_OK;
    pos = int'(item.position);
    case (item.cmd)
      CMD_APPEND: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = item.value;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_count--;
        end
      end
      CMD_INSERT: begin
        // Range is checked before fullness
        if (pos > shadow_count) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > pos; i--) begin
            shadow_words[i] = shadow_words[i-1];
          end
          shadow_words[pos] = item.value;
          shadow_count++;
        end
      end
      CMD_ERASE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_words[i] = shadow_words[i+1];
          end
          shadow_count--;
        end
      end
      CMD_READ: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          res.read_data = shadow_words[pos];
        end
      end
      CMD_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
        // Unused codes change nothing
      end
    endcase
    res.fill_count = 7'(shadow_count);
    return res;
  endfunction

  // Draw a wait count in 0..14; now and then enter a stretch with no waits.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 30);
    end
    return $urandom_range(0, 14);
  endfunction

  // Mostly a word of random bits, sometimes one of the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a position in 0..top, sometimes anywhere the field allows.
  function automatic logic [6:0] pick_pos(int top);
    if ($urandom_range(0, 7) == 0 || top < 0) begin
      return 7'($urandom_range(0, 127));
    end
    return 7'($urandom_range(0, top));
  endfunction

  // Queue one command and track the fill level the generator expects after it.
  task automatic push_cmd(logic [2:0] cmd, logic [6:0] pos, logic [31:0] val);
    in_t item;
    item.cmd      = cmd;
    item.position = pos;
    item.value    = val;
    cmd_q.insert(cmd_q.size(), item);
    case (cmd)
      CMD_APPEND: if (gen_level < DEPTH) gen_level++;
      CMD_REMOVE: if (gen_level > 0) gen_level--;
      CMD_INSERT: if (int'(pos) <= gen_level && gen_level < DEPTH) gen_level++;
      CMD_ERASE:  if (gen_level > 0 && int'(pos) < gen_level) gen_level--;
      CMD_CLEAR:  gen_level = 0;
      default: ;
    endcase
  endtask

  // Driver: present queued commands, hold each until the block takes it, and
  // predict the result as the transaction is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.insert(due_results.size(), apply_array_cmd(in_data));
        in_gap = draw_wait(in_calm);
      end
      // Hold valid and payload while a transaction is still pending
      if (!in_valid || in_ready) begin
        if (in_gap == 0 && cmd_q.size() != 0) begin
          in_data  <= cmd_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest owed one, then
  // stall the receiver for a freshly drawn number of cycles.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result with no command outstanding: read_data %0d fill_count %0d status %0d",
                 out_data.read_data, out_data.fill_count, out_data.status);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0d, actual %0d", want.read_data, out_data.read_data);
            fail_count++;
          end
          if (out_data.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, actual %0d", want.fill_count,
                   out_data.fill_count);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            fail_count++;
          end
        end
        out_stall = draw_wait(out_calm);
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up long after the slowest correct run would have finished
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int mode;
    int n;
    int r;
    int random_start;
    logic [2:0] cmd;

    // Directed part: empty-array refusals first
    push_cmd(CMD_READ,   7'd0,   32'h0);
    push_cmd(CMD_REMOVE, 7'd0,   32'h0);
    push_cmd(CMD_ERASE,  7'd0,   32'h0);
    push_cmd(CMD_INSERT, 7'd1,   32'h1234_5678);  // past the count
    // Build a few entries with extreme words
    push_cmd(CMD_INSERT, 7'd0,   32'h8000_0000);
    push_cmd(CMD_APPEND, 7'd127, 32'h7FFF_FFFF);
    push_cmd(CMD_APPEND, 7'd0,   32'h0000_0000);
    push_cmd(CMD_APPEND, 7'd0,   32'hFFFF_FFFF);
    push_cmd(CMD_INSERT, 7'd2,   32'h5555_5555);  // middle, shifts later entries up
    push_cmd(CMD_INSERT, 7'd5,   32'hAAAA_AAAA);  // at the count: acts as append
    // Front, back and refused reads
    push_cmd(CMD_READ,   7'd0,   32'h0);
    push_cmd(CMD_READ,   7'd5,   32'h0);
    push_cmd(CMD_READ,   7'd6,   32'h0);
    push_cmd(CMD_READ,   7'd127, 32'hFFFF_FFFF);
    // Refused erases at 6 and 127 leave the count alone; erases at 2 and 0 succeed
    push_cmd(CMD_ERASE,  7'd6,   32'h0);
    push_cmd(CMD_ERASE,  7'd127, 32'h0);
    push_cmd(CMD_ERASE,  7'd2,   32'h0);
    push_cmd(CMD_ERASE,  7'd0,   32'h0);
    // Unused codes are ignored; then remove, read, clear and a read of the cleared array
    push_cmd(3'd6,       7'd127, 32'hFFFF_FFFF);
    push_cmd(3'd7,       7'd0,   32'h0);
    push_cmd(CMD_REMOVE, 7'd0,   32'h0);
    push_cmd(CMD_READ,   7'd1,   32'h0);
    push_cmd(CMD_CLEAR,  7'd127, 32'hFFFF_FFFF);
    push_cmd(CMD_READ,   7'd0,   32'h0);

    // Random part: grow to full, drain to empty, mixed traffic, and clears
    random_start = cmd_q.size();
    while (cmd_q.size() - random_start < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        while (gen_level < DEPTH) begin
          if ($urandom_range(0, 1) == 1) begin
            push_cmd(CMD_APPEND, pick_pos(127), pick_value());
          end else begin
            push_cmd(CMD_INSERT, pick_pos(gen_level), pick_value());
          end
        end
        // Push against the full array
        n = $urandom_range(1, 4);
        repeat (n) begin
          cmd = ($urandom_range(0, 1) == 1) ? CMD_APPEND : CMD_INSERT;
          push_cmd(cmd, pick_pos(gen_level), pick_value());
        end
      end else if (mode < 5) begin
        while (gen_level > 0) begin
          if ($urandom_range(0, 1) == 1) begin
            push_cmd(CMD_REMOVE, pick_pos(127), pick_value());
          end else begin
            push_cmd(CMD_ERASE, pick_pos(gen_level - 1), pick_value());
          end
        end
        // Poke the empty array
        n = $urandom_range(1, 3);
        repeat (n) begin
          r = $urandom_range(0, 2);
          cmd = (r == 0) ? CMD_REMOVE : (r == 1) ? CMD_ERASE : CMD_READ;
          push_cmd(cmd, pick_pos(127), pick_value());
        end
      end else if (mode < 9) begin
        n = $urandom_range(20, 40);
        repeat (n) begin
          r = $urandom_range(0, 31);
          if (r < 8) begin
            push_cmd(CMD_APPEND, pick_pos(127), pick_value());
          end else if (r < 11) begin
            push_cmd(CMD_REMOVE, pick_pos(127), pick_value());
          end else if (r < 17) begin
            push_cmd(CMD_INSERT, pick_pos(gen_level), pick_value());
          end else if (r < 21) begin
            push_cmd(CMD_ERASE, pick_pos(gen_level - 1), pick_value());
          end else if (r < 29) begin
            push_cmd(CMD_READ, pick_pos(gen_level - 1), pick_value());
          end else if (r == 29) begin
            push_cmd(CMD_CLEAR, pick_pos(127), pick_value());
          end else begin
            push_cmd(3'(r - 24), pick_pos(127), pick_value());  // codes 6 and 7
          end
        end
      end else begin
        push_cmd(CMD_CLEAR, pick_pos(127), pick_value());
      end
    end

    // Release reset once
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: every command taken and every result returned; sample between
    // edges so the driver and monitor updates have settled
    while (cmd_q.size() != 0 || in_valid || due_results.size() != 0) begin
      @(negedge clk);
    end
    // Let any stray result show up before judging
    repeat (40) @(posedge clk);

    if (due_results.size() != 0) begin
      $error("%0d results never returned", due_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
